>>> hdl/nie_pkg.sv
// Shared types, codes and Q16.16 helper functions for the interpolation engine.
package nie_pkg;

  localparam logic signed [31:0] Q_ONE     = 32'sh0001_0000;
  localparam logic signed [47:0] SAT_MAX48 = 48'sh0000_7FFF_FFFF;
  localparam logic signed [47:0] SAT_MIN48 = -48'sh0000_8000_0000;
  localparam logic signed [31:0] Q_MAX     = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN     = 32'sh8000_0000;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_EVAL  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_FULL  = 3'd1,
    ST_EMPTY = 3'd2,
    ST_DUP   = 3'd3,
    ST_SAT   = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    C_RDI,
    C_LDI,
    C_J1,
    C_J2,
    C_J3,
    C_DIV,
    C_DWAIT,
    E_RD,
    E_D,
    E_Q1,
    E_Q2,
    E_M,
    E_T,
    S_DONE
  } state_t;

  // Round a Q32.32 product to Q32.16, ties toward plus infinity
  function automatic logic signed [47:0] q_round(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + 64'sd32768;
    return t[63:16];
  endfunction

  // Clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX48) begin
      r = Q_MAX;
    end else if (v < SAT_MIN48) begin
      r = Q_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Flag a value that sat32 would clamp
  function automatic logic ovf32(input logic signed [47:0] v);
    return (v > SAT_MAX48) || (v < SAT_MIN48);
  endfunction

endpackage

>>> hdl/nie_ram.sv
// Generic single-write, single-read RAM with registered read data.
module nie_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rd_r <= mem_r[raddr];
  end

  assign rdata = rd_r;

endmodule

>>> hdl/nie_div.sv
// Radix-2 restoring divider computing saturated (num * 2^16) / den, truncated toward zero.
module nie_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] num,
  input  logic signed [31:0] den,
  output logic               done,
  output logic signed [31:0] quot
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [47:0] dq_r, dq_nxt;
  logic [31:0] den_r, den_nxt;
  logic        neg_r, neg_nxt;
  logic [32:0] rem_sh;
  logic        ge;

  // One quotient bit per cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dq_nxt   = dq_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    rem_sh   = {rem_r, dq_r[47]};
    ge       = rem_sh >= {1'b0, den_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 6'd48;
      rem_nxt  = '0;
      dq_nxt   = {(num[31] ? (~num + 32'd1) : num), 16'd0};
      den_nxt  = den[31] ? (~den + 32'd1) : den;
      neg_nxt  = num[31] ^ den[31];
    end else if (busy_r) begin
      rem_nxt = ge ? 32'(rem_sh - {1'b0, den_r}) : rem_sh[31:0];
      dq_nxt  = {dq_r[46:0], ge};
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dq_r  <= dq_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  // Apply sign and clamp the magnitude
  always_comb begin
    if (neg_r) begin
      quot = (dq_r > 48'h0000_8000_0000) ? nie_pkg::Q_MIN : -$signed(dq_r[31:0]);
    end else begin
      quot = (dq_r > 48'h0000_7FFF_FFFF) ? nie_pkg::Q_MAX : $signed(dq_r[31:0]);
    end
  end

  assign done = done_r;

endmodule

>>> hdl/newton_interpolation_engine.sv
// Newton-form interpolation engine: node tables, coefficient pass and evaluation sequencer.
//
//   channel | direction | ports
//   in      | in        | in_valid, in_ready, in_action, in_point_x, in_point_y
//   out     | out       | out_valid, out_ready, out_value, out_status, out_node_count
//
// Load, clear, ACT_NONE and empty-table evaluate words finish in the cycle of acceptance.
// Evaluate with cached coefficients steps through the stored nodes one at a time;
// after a table change the coefficient pass first works through the nodes in order,
// each node ending in a division of its sum by its product in the bit-serial divider.
// One multiplier and single-port reads of the node and coefficient RAMs set the pace.
// Reset clears the state, count, cache flag and out_valid; RAM contents are never cleared.
// A new word is taken while a result waits, as long as out_ready frees the slot.
module newton_interpolation_engine #(
  parameter int unsigned MAX_POINTS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_action,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_value,
  output logic [2:0]         out_status,
  output logic [4:0]         out_node_count
);

  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);

  nie_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic               cv_r, cv_nxt;
  logic [CW-1:0]      i_r, i_nxt;
  logic [CW-1:0]      j_r, j_nxt;
  logic signed [31:0] xi_r, xi_nxt;
  logic signed [31:0] z_r, z_nxt;
  logic signed [31:0] s_r, s_nxt;
  logic signed [31:0] qv_r, qv_nxt;
  logic signed [31:0] d_r, d_nxt;
  logic signed [31:0] ch_r, ch_nxt;
  logic               sat_r, sat_nxt;
  logic signed [63:0] prod_r, prod_nxt;
  logic signed [31:0] res_value_r, res_value_nxt;
  nie_pkg::status_t   res_status_r, res_status_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic signed [31:0] out_value_r, out_value_nxt;
  nie_pkg::status_t   out_status_r, out_status_nxt;
  logic [CW-1:0]      out_count_r, out_count_nxt;

  logic               acc;
  logic               out_free;
  nie_pkg::action_t   act;
  logic [CW-1:0]      jn, in_n, km1;

  logic               xy_we, c_we;
  logic [AW-1:0]      xy_waddr, c_waddr, x_raddr, y_raddr, c_raddr;
  logic signed [31:0] x_rd, y_rd, c_rd;
  logic signed [31:0] c_wdata;
  logic               div_start, div_done;
  logic signed [31:0] div_quot;

  assign act      = nie_pkg::action_t'(in_action);
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == nie_pkg::S_IDLE) && out_free;
  assign acc      = in_valid && in_ready;
  assign jn       = j_r + CW'(1);
  assign in_n     = i_r + CW'(1);
  assign km1      = j_r - CW'(1);

  // Node and coefficient storage
  nie_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_xram (
    .clk(clk), .we(xy_we), .waddr(xy_waddr), .wdata(in_point_x),
    .raddr(x_raddr), .rdata(x_rd)
  );

  nie_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_yram (
    .clk(clk), .we(xy_we), .waddr(xy_waddr), .wdata(in_point_y),
    .raddr(y_raddr), .rdata(y_rd)
  );

  nie_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_cram (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .raddr(c_raddr), .rdata(c_rd)
  );

  nie_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(s_r), .den(qv_r),
    .done(div_done), .quot(div_quot)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      nie_pkg::S_IDLE: begin
        if (acc && act == nie_pkg::ACT_EVAL && count_r != '0) begin
          state_nxt = cv_r ? nie_pkg::E_RD : nie_pkg::C_RDI;
        end
      end
      nie_pkg::C_RDI: state_nxt = nie_pkg::C_LDI;
      nie_pkg::C_LDI: state_nxt = (i_r == '0) ? nie_pkg::C_DIV : nie_pkg::C_J1;
      nie_pkg::C_J1:  state_nxt = nie_pkg::C_J2;
      nie_pkg::C_J2:  state_nxt = nie_pkg::C_J3;
      nie_pkg::C_J3:  state_nxt = (jn < i_r) ? nie_pkg::C_J1 : nie_pkg::C_DIV;
      nie_pkg::C_DIV: state_nxt = (qv_r == '0) ? nie_pkg::S_DONE : nie_pkg::C_DWAIT;
      nie_pkg::C_DWAIT: begin
        if (div_done) begin
          state_nxt = (in_n < count_r) ? nie_pkg::C_RDI : nie_pkg::E_RD;
        end
      end
      nie_pkg::E_RD:  state_nxt = nie_pkg::E_D;
      nie_pkg::E_D:   state_nxt = (j_r == '0) ? nie_pkg::E_M : nie_pkg::E_Q1;
      nie_pkg::E_Q1:  state_nxt = nie_pkg::E_Q2;
      nie_pkg::E_Q2:  state_nxt = nie_pkg::E_M;
      nie_pkg::E_M:   state_nxt = nie_pkg::E_T;
      nie_pkg::E_T:   state_nxt = (jn < count_r) ? nie_pkg::E_RD : nie_pkg::S_DONE;
      nie_pkg::S_DONE: begin
        if (out_free) begin
          state_nxt = nie_pkg::S_IDLE;
        end
      end
      default: state_nxt = nie_pkg::S_IDLE;
    endcase
  end

  // Datapath, memory strobes and result word
  always_comb begin
    logic signed [31:0] mul_a, mul_b;
    logic signed [47:0] diff, sum, tq, qq;
    logic signed [31:0] t;

    count_nxt      = count_r;
    cv_nxt         = cv_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    xi_nxt         = xi_r;
    z_nxt          = z_r;
    s_nxt          = s_r;
    qv_nxt         = qv_r;
    d_nxt          = d_r;
    ch_nxt         = ch_r;
    sat_nxt        = sat_r;
    res_value_nxt  = res_value_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    xy_we          = 1'b0;
    c_we           = 1'b0;
    xy_waddr       = count_r[AW-1:0];
    c_waddr        = i_r[AW-1:0];
    c_wdata        = div_quot;
    x_raddr        = i_r[AW-1:0];
    y_raddr        = i_r[AW-1:0];
    c_raddr        = j_r[AW-1:0];
    div_start      = 1'b0;
    mul_a          = qv_r;
    mul_b          = d_r;
    tq             = nie_pkg::q_round(prod_r);
    t              = nie_pkg::sat32(tq);
    diff           = 48'(z_r) - 48'(x_rd);
    sum            = 48'(s_r) + 48'(t);
    qq             = tq;

    unique case (state_r)
      nie_pkg::S_IDLE: begin
        if (acc) begin
          z_nxt          = in_point_x;
          out_valid_nxt  = 1'b1;
          out_value_nxt  = '0;
          out_status_nxt = nie_pkg::ST_OK;
          unique case (act)
            nie_pkg::ACT_LOAD: begin
              if (count_r >= CW'(MAX_POINTS)) begin
                out_status_nxt = nie_pkg::ST_FULL;
              end else begin
                xy_we     = 1'b1;
                count_nxt = count_r + CW'(1);
                cv_nxt    = 1'b0;
              end
            end
            nie_pkg::ACT_CLEAR: begin
              count_nxt = '0;
              cv_nxt    = 1'b0;
            end
            nie_pkg::ACT_EVAL: begin
              if (count_r == '0) begin
                out_status_nxt = nie_pkg::ST_EMPTY;
              end else begin
                out_valid_nxt = out_valid_r && !out_ready;
                i_nxt         = '0;
                j_nxt         = '0;
                s_nxt         = '0;
                qv_nxt        = nie_pkg::Q_ONE;
                sat_nxt       = 1'b0;
              end
            end
            nie_pkg::ACT_NONE: begin
              out_status_nxt = nie_pkg::ST_OK;
            end
            default: out_status_nxt = nie_pkg::ST_OK;
          endcase
          out_count_nxt = count_nxt;
        end
      end
      nie_pkg::C_RDI: begin
        x_raddr = i_r[AW-1:0];
        y_raddr = i_r[AW-1:0];
      end
      nie_pkg::C_LDI: begin
        xi_nxt  = x_rd;
        s_nxt   = y_rd;
        qv_nxt  = nie_pkg::Q_ONE;
        j_nxt   = '0;
        x_raddr = '0;
        c_raddr = '0;
      end
      nie_pkg::C_J1: begin
        mul_a = c_rd;
        mul_b = qv_r;
        diff  = 48'(xi_r) - 48'(x_rd);
        d_nxt = nie_pkg::sat32(diff);
      end
      nie_pkg::C_J2: begin
        diff  = 48'(s_r) - 48'(t);
        s_nxt = nie_pkg::sat32(diff);
      end
      nie_pkg::C_J3: begin
        qv_nxt  = nie_pkg::sat32(qq);
        j_nxt   = jn;
        x_raddr = jn[AW-1:0];
        c_raddr = jn[AW-1:0];
      end
      nie_pkg::C_DIV: begin
        if (qv_r == '0) begin
          res_value_nxt  = '0;
          res_status_nxt = nie_pkg::ST_DUP;
        end else begin
          div_start = 1'b1;
        end
      end
      nie_pkg::C_DWAIT: begin
        if (div_done) begin
          c_we    = 1'b1;
          i_nxt   = in_n;
          j_nxt   = '0;
          s_nxt   = '0;
          qv_nxt  = nie_pkg::Q_ONE;
          sat_nxt = 1'b0;
        end
      end
      nie_pkg::E_RD: begin
        c_raddr = j_r[AW-1:0];
        x_raddr = km1[AW-1:0];
      end
      nie_pkg::E_D: begin
        ch_nxt = c_rd;
        if (j_r != '0) begin
          d_nxt   = nie_pkg::sat32(diff);
          sat_nxt = sat_r | nie_pkg::ovf32(diff);
        end
      end
      nie_pkg::E_Q1: begin
        mul_a = qv_r;
        mul_b = d_r;
      end
      nie_pkg::E_Q2: begin
        qv_nxt  = nie_pkg::sat32(qq);
        sat_nxt = sat_r | nie_pkg::ovf32(qq);
      end
      nie_pkg::E_M: begin
        mul_a = ch_r;
        mul_b = qv_r;
      end
      nie_pkg::E_T: begin
        s_nxt   = nie_pkg::sat32(sum);
        sat_nxt = sat_r | nie_pkg::ovf32(tq) | nie_pkg::ovf32(sum);
        j_nxt   = jn;
        if (!(jn < count_r)) begin
          res_value_nxt  = nie_pkg::sat32(sum);
          res_status_nxt = sat_nxt ? nie_pkg::ST_SAT : nie_pkg::ST_OK;
          cv_nxt         = 1'b1;
        end
      end
      nie_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = res_value_r;
          out_status_nxt = res_status_r;
          out_count_nxt  = count_r;
        end
      end
      default: begin
        out_valid_nxt = out_valid_r && !out_ready;
      end
    endcase

    prod_nxt = mul_a * mul_b;
  end

  // Control and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nie_pkg::S_IDLE;
      count_r     <= '0;
      cv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cv_r        <= cv_nxt;
      out_valid_r <= out_valid_nxt;
    end
    i_r          <= i_nxt;
    j_r          <= j_nxt;
    xi_r         <= xi_nxt;
    z_r          <= z_nxt;
    s_r          <= s_nxt;
    qv_r         <= qv_nxt;
    d_r          <= d_nxt;
    ch_r         <= ch_nxt;
    sat_r        <= sat_nxt;
    prod_r       <= prod_nxt;
    res_value_r  <= res_value_nxt;
    res_status_r <= res_status_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_value      = out_value_r;
  assign out_status     = out_status_r;
  assign out_node_count = 5'(out_count_r);

endmodule

>>> tb/sv/testbench.sv
// Testbench for the Newton-form interpolation engine: directed table, then random node sets.
`timescale 1ns / 1ps

module testbench;

  localparam int NODES      = 16;
  localparam int WORD_GOAL  = 1450;
  localparam int QUIET_TAIL = 150;
  localparam int HOLD_AT    = 200;
  localparam int HOLD_LEN   = 400;
  localparam int DIR_ROWS   = 30;

  typedef struct packed {
    logic signed [31:0] value;
    logic [2:0]         status;
    logic [4:0]         count;
  } result_t;

  typedef struct {
    nie_pkg::action_t   act;
    logic signed [31:0] x;
    logic signed [31:0] y;
    bit                 typed;
    result_t            res;
  } row_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         in_action;
  logic signed [31:0] in_point_x;
  logic signed [31:0] in_point_y;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] out_value;
  logic [2:0]         out_status;
  logic [4:0]         out_node_count;

  newton_interpolation_engine #(.MAX_POINTS(NODES)) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_point_x     (in_point_x),
    .in_point_y     (in_point_y),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_value      (out_value),
    .out_status     (out_status),
    .out_node_count (out_node_count)
  );

  // Shadow copy of the node table and coefficient cache
  logic signed [31:0] tbl_x [NODES];
  logic signed [31:0] tbl_y [NODES];
  logic signed [31:0] tbl_c [NODES];
  int                 tbl_n;
  bit                 tbl_cached;

  result_t pending_q [$];
  int      words_sent;
  int      fail_cnt;
  bit      quiet;
  bit      held;
  row_t    dir_tbl [DIR_ROWS];

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic signed [31:0] clamp32(input logic signed [63:0] v, inout bit hit);
    if (v > 64'sh7FFF_FFFF) begin
      hit = 1'b1;
      return nie_pkg::Q_MAX;
    end
    if (v < -64'sh8000_0000) begin
      hit = 1'b1;
      return nie_pkg::Q_MIN;
    end
    return v[31:0];
  endfunction

  // Q16.16 product, round to nearest with ties up, then clamp
  function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                             input logic signed [31:0] b, inout bit hit);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    p = (p + 64'sd32768) >>> 16;
    return clamp32(p, hit);
  endfunction

  // Divided-difference pass; returns 0 on a zero divisor
  function automatic bit build_coeffs();
    bit                 junk;
    logic signed [31:0] s;
    logic signed [31:0] qv;
    logic signed [31:0] t;
    logic signed [31:0] d;
    logic signed [63:0] num;
    junk = 1'b0;
    for (int i = 0; i < tbl_n; i++) begin
      s  = tbl_y[i];
      qv = nie_pkg::Q_ONE;
      for (int j = 0; j < i; j++) begin
        t  = qmul(tbl_c[j], qv, junk);
        s  = clamp32(64'(s) - 64'(t), junk);
        d  = clamp32(64'(tbl_x[i]) - 64'(tbl_x[j]), junk);
        qv = qmul(qv, d, junk);
      end
      if (qv == 0) return 1'b0;
      num      = 64'(s) * 64'sd65536;
      tbl_c[i] = clamp32(num / 64'(qv), junk);
    end
    return 1'b1;
  endfunction

  // Apply one word to the shadow state and return its result
  function automatic result_t interp_step(input logic [1:0] act,
                                          input logic signed [31:0] px,
                                          input logic signed [31:0] py);
    result_t            r;
    bit                 hit;
    logic signed [31:0] acc;
    logic signed [31:0] qv;
    logic signed [31:0] d;
    r.value  = '0;
    r.status = nie_pkg::ST_OK;
    hit      = 1'b0;
    case (act)
      nie_pkg::ACT_LOAD: begin
        if (tbl_n >= NODES) begin
          r.status = nie_pkg::ST_FULL;
        end else begin
          tbl_x[tbl_n] = px;
          tbl_y[tbl_n] = py;
          tbl_n++;
          tbl_cached = 1'b0;
        end
      end
      nie_pkg::ACT_CLEAR: begin
        tbl_n      = 0;
        tbl_cached = 1'b0;
      end
      nie_pkg::ACT_EVAL: begin
        if (tbl_n == 0) begin
          r.status = nie_pkg::ST_EMPTY;
        end else if (!tbl_cached && !build_coeffs()) begin
          r.status = nie_pkg::ST_DUP;
        end else begin
          tbl_cached = 1'b1;
          acc = '0;
          qv  = nie_pkg::Q_ONE;
          for (int i = 0; i < tbl_n; i++) begin
            if (i > 0) begin
              d  = clamp32(64'(px) - 64'(tbl_x[i-1]), hit);
              qv = qmul(qv, d, hit);
            end
            acc = clamp32(64'(acc) + 64'(qmul(tbl_c[i], qv, hit)), hit);
          end
          r.value = acc;
          if (hit) r.status = nie_pkg::ST_SAT;
        end
      end
      default: ;
    endcase
    r.count = 5'(tbl_n);
    return r;
  endfunction

  // Offer one word, wait for acceptance, queue its expected result
  task automatic send_word(input logic [1:0] act, input logic signed [31:0] px,
                           input logic signed [31:0] py, input bit typed, input result_t res);
    result_t r;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_action  <= act;
    in_point_x <= px;
    in_point_y <= py;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = interp_step(act, px, py);
    pending_q.push_back(typed ? res : r);
    words_sent++;
    if (words_sent >= WORD_GOAL - QUIET_TAIL) quiet = 1'b1;
  endtask

  function automatic logic signed [31:0] pick_q(input bit wide);
    if (wide) return $urandom;
    return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
  endfunction

  // Check each result word against the oldest expectation
  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        $error("unexpected result word: value %0d status %0d count %0d",
               out_value, out_status, out_node_count);
        fail_cnt++;
      end else begin
        e = pending_q.pop_front();
        if (out_value !== e.value) begin
          $error("value: expected %0d, actual %0d", e.value, out_value);
          fail_cnt++;
        end
        if (out_status !== e.status) begin
          $error("status: expected %0d, actual %0d", e.status, out_status);
          fail_cnt++;
        end
        if (out_node_count !== e.count) begin
          $error("node_count: expected %0d, actual %0d", e.count, out_node_count);
          fail_cnt++;
        end
      end
    end
  end

  // Result side: random stalls plus one long hold-off to back the block up
  initial begin
    out_ready <= 1'b0;
    held = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held && words_sent >= HOLD_AT) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin
    int                 nodes;
    int                 evals;
    bit                 wide;
    logic signed [31:0] x;
    logic signed [31:0] last_x;
    result_t            none;

    none       = '0;
    tbl_n      = 0;
    tbl_cached = 1'b0;
    words_sent = 0;
    fail_cnt   = 0;
    quiet      = 1'b0;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_action  <= nie_pkg::ACT_NONE;
    in_point_x <= '0;
    in_point_y <= '0;

    // Directed rows: typed results where obvious, predicted otherwise
    dir_tbl[0]  = '{nie_pkg::ACT_EVAL, 32'sd0, 32'sd0, 1,
                    '{32'sd0, nie_pkg::ST_EMPTY, 5'd0}};
    dir_tbl[1]  = '{nie_pkg::ACT_NONE, nie_pkg::Q_MAX, nie_pkg::Q_MIN, 1,
                    '{32'sd0, nie_pkg::ST_OK, 5'd0}};
    dir_tbl[2]  = '{nie_pkg::ACT_LOAD, 32'sd0, nie_pkg::Q_MAX, 1,
                    '{32'sd0, nie_pkg::ST_OK, 5'd1}};
    dir_tbl[3]  = '{nie_pkg::ACT_EVAL, nie_pkg::Q_MIN, 32'sd0, 1,
                    '{nie_pkg::Q_MAX, nie_pkg::ST_OK, 5'd1}};
    dir_tbl[4]  = '{nie_pkg::ACT_LOAD, 32'sd0, 32'sd0, 1,
                    '{32'sd0, nie_pkg::ST_OK, 5'd2}};
    dir_tbl[5]  = '{nie_pkg::ACT_EVAL, nie_pkg::Q_ONE, 32'sd0, 1,
                    '{32'sd0, nie_pkg::ST_DUP, 5'd2}};
    dir_tbl[6]  = '{nie_pkg::ACT_CLEAR, nie_pkg::Q_MIN, nie_pkg::Q_MAX, 1,
                    '{32'sd0, nie_pkg::ST_OK, 5'd0}};
    dir_tbl[7]  = '{nie_pkg::ACT_LOAD, nie_pkg::Q_MIN, nie_pkg::Q_MIN, 1,
                    '{32'sd0, nie_pkg::ST_OK, 5'd1}};
    dir_tbl[8]  = '{nie_pkg::ACT_LOAD, nie_pkg::Q_MAX, nie_pkg::Q_MAX, 1,
                    '{32'sd0, nie_pkg::ST_OK, 5'd2}};
    dir_tbl[9]  = '{nie_pkg::ACT_EVAL, nie_pkg::Q_MAX, 32'sd0, 0, none};
    dir_tbl[10] = '{nie_pkg::ACT_EVAL, 32'sd0, 32'sd0, 0, none};
    dir_tbl[11] = '{nie_pkg::ACT_CLEAR, 32'sd0, 32'sd0, 1,
                    '{32'sd0, nie_pkg::ST_OK, 5'd0}};
    for (int k = 12; k < 12 + NODES; k++)
      dir_tbl[k] = '{nie_pkg::ACT_LOAD, (k - 19) * nie_pkg::Q_ONE, (k * k) <<< 12, 0, none};
    dir_tbl[28] = '{nie_pkg::ACT_LOAD, nie_pkg::Q_ONE, nie_pkg::Q_ONE, 1,
                    '{32'sd0, nie_pkg::ST_FULL, 5'(NODES)}};
    dir_tbl[29] = '{nie_pkg::ACT_EVAL, 32'sh0000_8000, 32'sd0, 0, none};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tbl[i])
      send_word(dir_tbl[i].act, dir_tbl[i].x, dir_tbl[i].y, dir_tbl[i].typed, dir_tbl[i].res);

    // Random node sets: clear, load, evaluate, with some noise words
    last_x = '0;
    while (words_sent < WORD_GOAL) begin
      send_word(nie_pkg::ACT_CLEAR, $urandom, $urandom, 0, none);
      wide  = ($urandom_range(0, 4) == 0);
      nodes = ($urandom_range(0, 19) == 0) ? $urandom_range(14, NODES + 2)
                                           : $urandom_range(1, 6);
      for (int k = 0; k < nodes; k++) begin
        x = ($urandom_range(0, 14) == 0 && k > 0) ? last_x : pick_q(wide);
        last_x = x;
        send_word(nie_pkg::ACT_LOAD, x, pick_q(wide || $urandom_range(0, 5) == 0), 0, none);
        if ($urandom_range(0, 9) == 0)
          send_word($urandom_range(0, 1) ? nie_pkg::ACT_NONE : nie_pkg::ACT_EVAL,
                    $urandom, $urandom, 0, none);
      end
      evals = $urandom_range(1, 4);
      for (int k = 0; k < evals; k++)
        send_word(nie_pkg::ACT_EVAL, pick_q(wide || $urandom_range(0, 7) == 0), $urandom,
                  0, none);
    end
    in_valid <= 1'b0;

    // Drain, then give the block a short settle window
    while (pending_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> newton_interpolation_engine.f
hdl/nie_pkg.sv
hdl/nie_ram.sv
hdl/nie_div.sv
hdl/newton_interpolation_engine.sv
tb/sv/testbench.sv
